// ----- sv/ppd_pkg.sv -----
// Shared types and constants of the packed pattern decoder.
package ppd_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned RowW     = 6;
    localparam int unsigned RowCntW  = 7;
    localparam int unsigned ChanW    = 5;
    localparam int unsigned CountW   = 6;
    localparam int unsigned FlagW    = 3;
    localparam int unsigned HeldN    = 4;

    localparam logic [RowCntW-1:0] RowSat      = 7'd127;
    localparam logic [CountW-1:0]  LimitReset  = 6'd32;
    localparam logic [ChanW-1:0]   HighReset   = 5'd1;

    // One result item as it sits in the output queue.
    typedef struct packed {
        logic              is_summary;
        logic [RowW-1:0]   row;
        logic [ChanW-1:0]  channel;
        logic              has_note;
        logic [ByteW-1:0]  note;
        logic [ByteW-1:0]  instrument;
        logic              has_effect;
        logic [ByteW-1:0]  effect;
        logic [ByteW-1:0]  param;
        logic              has_volume;
        logic [ByteW-1:0]  volume;
        logic [CountW-1:0] channel_count;
    } t_result;

    // What the decoder hands to the output queue for one accepted byte.
    typedef struct packed {
        logic    ev_valid;
        logic    sum_valid;
        t_result ev;
        t_result sum;
    } t_dec_out;

endpackage

// ----- sv/ppd_if.sv -----
// Valid/ready channel interfaces for the input bytes and the result items.
interface ppd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last;

    modport source (output valid, output packed_byte, output last, input ready);
    modport sink   (input valid, input packed_byte, input last, output ready);
endinterface

interface ppd_out_if;
    logic       valid;
    logic       ready;
    logic       is_summary;
    logic [5:0] row;
    logic [4:0] channel;
    logic       has_note;
    logic [7:0] note;
    logic [7:0] instrument;
    logic       has_effect;
    logic [7:0] effect;
    logic [7:0] param;
    logic       has_volume;
    logic [7:0] volume;
    logic [5:0] channel_count;

    modport source (
        output valid, input ready,
        output is_summary, output row, output channel,
        output has_note, output note, output instrument,
        output has_effect, output effect, output param,
        output has_volume, output volume, output channel_count
    );
    modport sink (
        input valid, output ready,
        input is_summary, input row, input channel,
        input has_note, input note, input instrument,
        input has_effect, input effect, input param,
        input has_volume, input volume, input channel_count
    );
endinterface

// ----- sv/ppd_decode.sv -----
// Byte decoder: phase tracking, held payload bytes and event/summary forming.
module ppd_decode #(
    parameter int unsigned ROWS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [ppd_pkg::ByteW-1:0]     i_byte,
    input  logic                          i_last,
    input  logic                          i_cfg_we,
    input  logic [ppd_pkg::CountW-1:0]    i_cfg_data,
    output ppd_pkg::t_dec_out             o_dec
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NOTE   = 3'd1,
        PH_INSTR  = 3'd2,
        PH_EFFECT = 3'd3,
        PH_PARAM  = 3'd4,
        PH_VOLUME = 3'd5
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [ppd_pkg::RowCntW-1:0]     r_row, n_row;
    logic [ppd_pkg::ChanW-1:0]       r_chan, n_chan;
    logic [ppd_pkg::FlagW-1:0]       r_flags, n_flags;
    logic [ppd_pkg::ByteW-1:0]       r_held [ppd_pkg::HeldN];
    logic [ppd_pkg::ByteW-1:0]       n_held [ppd_pkg::HeldN];
    logic [ppd_pkg::ChanW-1:0]       r_high, n_high;
    logic [ppd_pkg::CountW-1:0]      r_limit;

    logic                            done;
    logic [ppd_pkg::ByteW-1:0]       vol;
    logic [ppd_pkg::CountW-1:0]      lim;
    logic [ppd_pkg::CountW-1:0]      cnt;

    // Next payload step after step "from"; flag bit 0 note, 1 effect, 2 volume.
    function automatic t_phase next_phase(t_phase from, logic [2:0] flags);
        t_phase res;
        res = PH_HEADER;
        if (from < PH_VOLUME && flags[2]) res = PH_VOLUME;
        if (from < PH_EFFECT && flags[1]) res = PH_EFFECT;
        if (from < PH_NOTE && flags[0]) res = PH_NOTE;
        return res;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_chan  = r_chan;
        n_flags = r_flags;
        n_held  = r_held;
        n_high  = r_high;
        done    = 1'b0;
        vol     = '0;
        case (r_phase)
            PH_HEADER: begin
                if (i_byte == '0) begin
                    if (r_row != ppd_pkg::RowSat) n_row = r_row + 1'b1;
                end else begin
                    n_chan  = i_byte[ppd_pkg::ChanW-1:0];
                    n_flags = i_byte[7:5];
                    if (n_chan > r_high) n_high = n_chan;
                    for (int k = 0; k < ppd_pkg::HeldN; k++) n_held[k] = '0;
                    n_phase = next_phase(PH_HEADER, i_byte[7:5]);
                    done    = (n_phase == PH_HEADER);
                end
            end
            PH_NOTE: begin
                n_held[0] = i_byte;
                n_phase   = PH_INSTR;
            end
            PH_INSTR: begin
                n_held[1] = i_byte;
                n_phase   = next_phase(PH_INSTR, r_flags);
                done      = (n_phase == PH_HEADER);
            end
            PH_EFFECT: begin
                n_held[2] = i_byte;
                n_phase   = PH_PARAM;
            end
            PH_PARAM: begin
                n_held[3] = i_byte;
                n_phase   = next_phase(PH_PARAM, r_flags);
                done      = (n_phase == PH_HEADER);
            end
            PH_VOLUME: begin
                vol     = i_byte;
                n_phase = PH_HEADER;
                done    = 1'b1;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    // A limit of zero behaves as one; count is highest channel plus one.
    always_comb begin
        lim = (r_limit == '0) ? ppd_pkg::CountW'(1) : r_limit;
        cnt = ppd_pkg::CountW'(n_high) + 1'b1;
        if (cnt > lim) cnt = lim;
    end

    always_comb begin
        o_dec                   = '0;
        o_dec.ev_valid          = i_accept && done && (r_row < ppd_pkg::RowCntW'(ROWS));
        o_dec.ev.row            = r_row[ppd_pkg::RowW-1:0];
        o_dec.ev.channel        = n_chan;
        o_dec.ev.has_note       = n_flags[0];
        o_dec.ev.note           = n_flags[0] ? n_held[0] : '0;
        o_dec.ev.instrument     = n_flags[0] ? n_held[1] : '0;
        o_dec.ev.has_effect     = n_flags[1];
        o_dec.ev.effect         = n_flags[1] ? n_held[2] : '0;
        o_dec.ev.param          = n_flags[1] ? n_held[3] : '0;
        o_dec.ev.has_volume     = n_flags[2];
        o_dec.ev.volume         = n_flags[2] ? vol : '0;
        o_dec.sum_valid         = i_accept && i_last;
        o_dec.sum.is_summary    = 1'b1;
        o_dec.sum.channel_count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_row   <= '0;
            r_chan  <= '0;
            r_flags <= '0;
            r_high  <= ppd_pkg::HighReset;
            r_limit <= ppd_pkg::LimitReset;
            for (int k = 0; k < ppd_pkg::HeldN; k++) r_held[k] <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (i_accept) begin
                if (i_last) begin
                    // The pattern ends here: start the next one from scratch.
                    r_phase <= PH_HEADER;
                    r_row   <= '0;
                    r_chan  <= '0;
                    r_flags <= '0;
                    r_high  <= ppd_pkg::HighReset;
                    for (int k = 0; k < ppd_pkg::HeldN; k++) r_held[k] <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_row   <= n_row;
                    r_chan  <= n_chan;
                    r_flags <= n_flags;
                    r_high  <= n_high;
                    r_held  <= n_held;
                end
            end
        end
    end

endmodule

// ----- sv/ppd_outq.sv -----
// Four-entry result queue that takes up to two items per cycle and gives one.
module ppd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppd_pkg::t_dec_out i_dec,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output ppd_pkg::t_result  o_item
);

    localparam int unsigned Depth = 4;
    localparam int unsigned PtrW  = $clog2(Depth);

    ppd_pkg::t_result     r_mem [Depth];
    logic [PtrW-1:0]      r_wp, n_wp;
    logic [PtrW-1:0]      r_rp, n_rp;
    logic [PtrW:0]        r_cnt, n_cnt;
    logic [1:0]           nwr;
    logic                 pop;
    ppd_pkg::t_result     w0;

    always_comb begin
        nwr   = {1'b0, i_dec.ev_valid} + {1'b0, i_dec.sum_valid};
        w0    = i_dec.ev_valid ? i_dec.ev : i_dec.sum;
        pop   = o_valid && i_ready;
        n_wp  = r_wp + PtrW'(nwr);
        n_rp  = r_rp + PtrW'(pop);
        n_cnt = r_cnt + (PtrW+1)'(nwr) - (PtrW+1)'(pop);
    end

    // Two free entries are kept so that any byte can be taken.
    assign o_room  = (r_cnt <= (PtrW+1)'(Depth - 2));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nwr != 2'd0) r_mem[r_wp] <= w0;
        if (nwr == 2'd2) r_mem[r_wp + 1'b1] <= i_dec.sum;
    end

endmodule

// ----- sv/packed_pattern_decoder.sv -----
// Top level of the packed pattern decoder: byte decoder followed by result queue.
//
// This block decodes the packed byte stream of one tracker pattern and takes one
// byte per clock cycle while the result queue has room. A zero header byte
// advances the row; any other header byte names a channel in its low five bits
// and announces note and instrument (bit 5), effect and parameter (bit 6) and
// volume (bit 7) bytes, which follow in that order. When the last byte of an
// event has been taken, a cell event with row, channel, presence flags and raw
// bytes is produced; payload fields whose flag is clear read as zero. Events on
// rows at or beyond ROWS are not produced, though their channel still counts.
// The byte marked last is decoded as usual and then followed by a summary item
// whose channel_count is the highest channel seen (at least one) plus one,
// clamped to channel_limit (a limit of zero acts as one); an unfinished event is
// dropped and the decoder starts the next pattern from its reset state. Each
// byte is decoded in the cycle of its transfer and its results are written into
// a four-entry result queue that takes up to two items in one cycle; input ready
// stays high while at least two entries are free, so with the output side
// taking results freely a byte is taken in every cycle, and the throughput limit
// is the output port's one transfer per cycle. channel_limit resets to 32 and is
// written through i_cfg_we/i_cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce.
module packed_pattern_decoder #(
    parameter int unsigned ROWS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ppd_pkg::CountW-1:0] i_cfg_data,
    ppd_in_if.sink                     i_in,
    ppd_out_if.source                  o_out
);

    logic              accept;
    logic              room;
    ppd_pkg::t_dec_out dec;
    ppd_pkg::t_result  item;

    // A byte transfers when the queue has room for the two items it may cause.
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    ppd_decode #(
        .ROWS (ROWS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_in.packed_byte),
        .i_last     (i_in.last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_dec      (dec)
    );

    ppd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dec   (dec),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (item)
    );

    assign o_out.is_summary    = item.is_summary;
    assign o_out.row           = item.row;
    assign o_out.channel       = item.channel;
    assign o_out.has_note      = item.has_note;
    assign o_out.note          = item.note;
    assign o_out.instrument    = item.instrument;
    assign o_out.has_effect    = item.has_effect;
    assign o_out.effect        = item.effect;
    assign o_out.param         = item.param;
    assign o_out.has_volume    = item.has_volume;
    assign o_out.volume        = item.volume;
    assign o_out.channel_count = item.channel_count;

endmodule
